FILE: rtl/core/i64alu_pkg.sv
`timescale 1ns / 1ps
package i64alu_pkg;

    typedef struct packed {
        logic [4:0]         func;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
    } t_in;

    typedef struct packed {
        logic signed [63:0] result;
        logic [1:0]         error_code;
    } t_out;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_POW  = 5'd3,
        OP_DIV  = 5'd4,
        OP_MOD  = 5'd5,
        OP_LT   = 5'd6,
        OP_LE   = 5'd7,
        OP_GT   = 5'd8,
        OP_GE   = 5'd9,
        OP_EQ   = 5'd10,
        OP_NE   = 5'd11,
        OP_OR   = 5'd12,
        OP_AND  = 5'd13,
        OP_LOR  = 5'd14,
        OP_LAND = 5'd15,
        OP_SHL  = 5'd16,
        OP_SHR  = 5'd17,
        OP_PLUS = 5'd18,
        OP_NEG  = 5'd19,
        OP_LNOT = 5'd20,
        OP_BNOT = 5'd21
    } t_func;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_SHIFT = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_W,
        S_DIV_W,
        S_POW_BIT,
        S_POW_RW,
        S_POW_SH,
        S_POW_CW,
        S_POW_END,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MS_WRAP,
        MS_RC,
        MS_CC
    } t_msrc;

    typedef enum logic [1:0] {
        RS_SIMPLE,
        RS_MUL,
        RS_DIV,
        RS_POW
    } t_rsrc;

    typedef struct packed {
        logic  load;
        logic  mul_start;
        t_msrc msrc;
        logic  div_start;
        logic  pow_init;
        logic  r_upd;
        logic  c_upd;
        logic  e_shift;
        logic  sat_set;
        logic  res_we;
        t_rsrc rsrc;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic go_mul;
        logic go_div;
        logic go_pow;
        logic mul_done;
        logic mul_ovf;
        logic div_done;
        logic e_bit0;
        logic e_hi_zero;
    } t_status;

endpackage

FILE: rtl/core/i64alu_ctrl.sv
`timescale 1ns / 1ps
module i64alu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  i64alu_pkg::t_status i_st,
    output i64alu_pkg::t_cmd    o_cmd
);
    import i64alu_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.msrc = MS_WRAP;
        cmd.rsrc = RS_SIMPLE;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_st.go_mul) begin
                    cmd.mul_start = 1'b1;
                    cmd.msrc      = MS_WRAP;
                    n_state       = S_MUL_W;
                end else if (i_st.go_div) begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIV_W;
                end else if (i_st.go_pow) begin
                    cmd.pow_init = 1'b1;
                    n_state      = S_POW_BIT;
                end else begin
                    cmd.res_we = 1'b1;
                    cmd.rsrc   = RS_SIMPLE;
                    n_state    = S_OUT;
                end
            end
            S_MUL_W: begin
                if (i_st.mul_done) begin
                    cmd.res_we = 1'b1;
                    cmd.rsrc   = RS_MUL;
                    n_state    = S_OUT;
                end
            end
            S_DIV_W: begin
                if (i_st.div_done) begin
                    cmd.res_we = 1'b1;
                    cmd.rsrc   = RS_DIV;
                    n_state    = S_OUT;
                end
            end
            S_POW_BIT: begin
                if (i_st.e_bit0) begin
                    cmd.mul_start = 1'b1;
                    cmd.msrc      = MS_RC;
                    n_state       = S_POW_RW;
                end else begin
                    n_state = S_POW_SH;
                end
            end
            S_POW_RW: begin
                if (i_st.mul_done) begin
                    if (i_st.mul_ovf) begin
                        cmd.sat_set = 1'b1;
                        n_state     = S_POW_END;
                    end else begin
                        cmd.r_upd = 1'b1;
                        n_state   = S_POW_SH;
                    end
                end
            end
            S_POW_SH: begin
                if (i_st.e_hi_zero) begin
                    n_state = S_POW_END;
                end else begin
                    cmd.e_shift   = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.msrc      = MS_CC;
                    n_state       = S_POW_CW;
                end
            end
            S_POW_CW: begin
                if (i_st.mul_done) begin
                    if (i_st.mul_ovf) begin
                        cmd.sat_set = 1'b1;
                        n_state     = S_POW_END;
                    end else begin
                        cmd.c_upd = 1'b1;
                        n_state   = S_POW_BIT;
                    end
                end
            end
            S_POW_END: begin
                cmd.res_we = 1'b1;
                cmd.rsrc   = RS_POW;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output overwritten while pending");
    a_mul_done_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.mul_done |-> (r_state == S_MUL_W || r_state == S_POW_RW || r_state == S_POW_CW))
        else $error("multiplier done outside a wait state");
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");
`endif

endmodule

FILE: rtl/core/i64alu_dp.sv
`timescale 1ns / 1ps
module i64alu_dp #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i64alu_pkg::t_in     i_in,
    input  i64alu_pkg::t_cmd    i_cmd,
    output i64alu_pkg::t_status o_st,
    output i64alu_pkg::t_out    o_out
);
    import i64alu_pkg::*;

    localparam logic [63:0] W_MASK   = {64{1'b1}} >> (64 - DATA_WIDTH);
    localparam logic [63:0] W_SIGN   = 64'd1 << (DATA_WIDTH - 1);
    localparam logic [63:0] W_MAXPOS = W_SIGN - 64'd1;
    localparam logic [63:0] W_LEN    = 64'(DATA_WIDTH);

    function automatic logic [63:0] sx(input logic [63:0] v);
        sx = ((v & W_SIGN) != 64'd0) ? (v | ~W_MASK) : (v & W_MASK);
    endfunction

    t_func       r_op;
    logic [63:0] r_a, r_b;
    logic [63:0] mag_a, mag_b;

    // multiplier
    logic [63:0]  r_mx, r_my, r_pp;
    logic [2:0]   r_mcnt;
    logic [1:0]   r_psh;
    logic         r_mbusy, r_mdone;
    logic [127:0] r_acc;
    t_msrc        r_msrc;
    logic [31:0]  ha, hb;
    logic [63:0]  pp_n, limit;

    // divider
    logic [63:0] r_dq, r_rem, r_dv;
    logic [5:0]  r_dcnt;
    logic        r_dbusy, r_ddone;
    logic [64:0] rem_sh, diff;

    // power
    logic [63:0] r_rmag, r_cmag;
    logic        r_rneg, r_cneg, r_sat;
    logic [31:0] r_e;

    logic [63:0] s_res;
    t_err        s_err;
    logic        b_zero, sh_bad;
    logic [63:0] div_res, pow_res;

    t_out r_res, r_out;

    assign mag_a  = r_a[63] ? (64'd0 - r_a) : r_a;
    assign mag_b  = r_b[63] ? (64'd0 - r_b) : r_b;
    assign b_zero = (r_b == 64'd0);
    assign sh_bad = r_b[63] || (r_b >= W_LEN);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_func'(i_in.func);
            r_a  <= sx(64'(i_in.lhs));
            r_b  <= sx(64'(i_in.rhs));
        end
    end

    always_comb begin
        s_res = 64'd0;
        s_err = ERR_NONE;
        unique case (r_op) inside
            OP_ADD:  s_res = r_a + r_b;
            OP_SUB:  s_res = r_a - r_b;
            OP_POW: begin
                if (!r_b[63] && r_b[31:0] == 32'd0) s_res = 64'd1;
            end
            OP_DIV, OP_MOD: begin
                if (b_zero) s_err = ERR_DIV0;
            end
            OP_LT:   s_res = {63'd0, $signed(r_a) < $signed(r_b)};
            OP_LE:   s_res = {63'd0, $signed(r_a) <= $signed(r_b)};
            OP_GT:   s_res = {63'd0, $signed(r_a) > $signed(r_b)};
            OP_GE:   s_res = {63'd0, $signed(r_a) >= $signed(r_b)};
            OP_EQ:   s_res = {63'd0, r_a == r_b};
            OP_NE:   s_res = {63'd0, r_a != r_b};
            OP_OR:   s_res = r_a | r_b;
            OP_AND:  s_res = r_a & r_b;
            OP_LOR:  s_res = {63'd0, (r_a != 64'd0) || (r_b != 64'd0)};
            OP_LAND: s_res = {63'd0, (r_a != 64'd0) && (r_b != 64'd0)};
            OP_SHL, OP_SHR: begin
                if (sh_bad) begin
                    s_err = ERR_SHIFT;
                end else if (r_op == OP_SHL) begin
                    s_res = r_a << r_b[5:0];
                end else begin
                    s_res = 64'($signed(r_a) >>> r_b[5:0]);
                end
            end
            OP_PLUS: s_res = r_a;
            OP_NEG:  s_res = 64'd0 - r_a;
            OP_LNOT: s_res = {63'd0, r_a == 64'd0};
            OP_BNOT: s_res = ~r_a;
            default: s_res = 64'd0;
        endcase
    end

    assign o_st.go_mul = (r_op == OP_MUL);
    assign o_st.go_div = (r_op == OP_DIV || r_op == OP_MOD) && !b_zero;
    assign o_st.go_pow = (r_op == OP_POW) && !r_b[63] && (r_b[31:0] != 32'd0)
                         && (mag_a != 64'd0);

    // four 32x32 partial products, each registered before it is accumulated
    assign ha    = r_mcnt[1] ? r_mx[63:32] : r_mx[31:0];
    assign hb    = r_mcnt[0] ? r_my[63:32] : r_my[31:0];
    assign pp_n  = {32'd0, ha} * {32'd0, hb};
    assign limit = (r_msrc == MS_RC && (r_rneg != r_cneg)) ? W_SIGN : W_MAXPOS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
        end else begin
            r_mdone <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
            end else if (r_mbusy && r_mcnt == 3'd4) begin
                r_mbusy <= 1'b0;
                r_mdone <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_msrc <= i_cmd.msrc;
            r_mcnt <= 3'd0;
            r_acc  <= 128'd0;
            unique case (i_cmd.msrc)
                MS_WRAP: begin
                    r_mx <= r_a;
                    r_my <= r_b;
                end
                MS_RC: begin
                    r_mx <= r_rmag;
                    r_my <= r_cmag;
                end
                default: begin
                    r_mx <= r_cmag;
                    r_my <= r_cmag;
                end
            endcase
        end else if (r_mbusy) begin
            r_mcnt <= r_mcnt + 3'd1;
            if (r_mcnt != 3'd4) begin
                r_pp  <= pp_n;
                r_psh <= {1'b0, r_mcnt[1]} + {1'b0, r_mcnt[0]};
            end
            if (r_mcnt != 3'd0) begin
                r_acc <= r_acc + ({64'd0, r_pp} << {r_psh, 5'd0});
            end
        end
    end

    assign o_st.mul_done = r_mdone;
    assign o_st.mul_ovf  = (r_acc[127:64] != 64'd0) || (r_acc[63:0] > limit);

    // restoring divider on magnitudes, one quotient bit per cycle
    assign rem_sh = {r_rem, r_dq[63]};
    assign diff   = rem_sh - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt == 6'd63) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq   <= mag_a;
            r_dv   <= mag_b;
            r_rem  <= 64'd0;
            r_dcnt <= 6'd0;
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt + 6'd1;
            r_dq   <= {r_dq[62:0], ~diff[64]};
            r_rem  <= diff[64] ? rem_sh[63:0] : diff[63:0];
        end
    end

    assign o_st.div_done = r_ddone;

    always_comb begin
        if (r_op == OP_DIV) begin
            div_res = (r_a[63] != r_b[63]) ? (64'd0 - r_dq) : r_dq;
        end else begin
            div_res = r_a[63] ? (64'd0 - r_rem) : r_rem;
        end
    end

    // square and multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.pow_init) begin
            r_rmag <= 64'd1;
            r_rneg <= 1'b0;
            r_cmag <= mag_a;
            r_cneg <= r_a[63];
            r_e    <= r_b[31:0];
            r_sat  <= 1'b0;
        end else begin
            if (i_cmd.r_upd) begin
                r_rmag <= r_acc[63:0];
                r_rneg <= r_rneg ^ r_cneg;
            end
            if (i_cmd.c_upd) begin
                r_cmag <= r_acc[63:0];
                r_cneg <= 1'b0;
            end
            if (i_cmd.e_shift) r_e <= {1'b0, r_e[31:1]};
            if (i_cmd.sat_set) r_sat <= 1'b1;
        end
    end

    assign o_st.e_bit0    = r_e[0];
    assign o_st.e_hi_zero = (r_e[31:1] == 31'd0);
    assign pow_res = r_sat ? W_MAXPOS : (r_rneg ? (64'd0 - r_rmag) : r_rmag);

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_we) begin
            unique case (i_cmd.rsrc)
                RS_SIMPLE: begin
                    r_res.result     <= sx(s_res);
                    r_res.error_code <= 2'(s_err);
                end
                RS_MUL: begin
                    r_res.result     <= sx(r_acc[63:0]);
                    r_res.error_code <= 2'(ERR_NONE);
                end
                RS_DIV: begin
                    r_res.result     <= sx(div_res);
                    r_res.error_code <= 2'(ERR_NONE);
                end
                default: begin
                    r_res.result     <= sx(pow_res);
                    r_res.error_code <= 2'(ERR_NONE);
                end
            endcase
        end
        if (i_cmd.out_load) r_out <= r_res;
    end

    assign o_out = r_out;

endmodule

FILE: rtl/core/int64_alu_with_saturating_power.sv
`timescale 1ns / 1ps
// Signed DATA_WIDTH-bit ALU, one item at a time. Simple operations take a
// combinational path into the result register; wrapping multiply runs on a
// four-step 32x32 partial-product multiplier, div and mod on a one-bit-per-cycle
// restoring divider, and power by square and multiply, where each exponent bit
// costs up to two multiplies on that same multiplier. The next item is accepted
// the cycle after the previous result is loaded into the output register.
module int64_alu_with_saturating_power #(
    parameter int DATA_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  i64alu_pkg::t_in   i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output i64alu_pkg::t_out  o_out
);
    import i64alu_pkg::*;

    t_cmd    cmd;
    t_status st;

    i64alu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    i64alu_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_st    (st),
        .o_out   (o_out)
    );

endmodule

FILE: bench/int64_alu_with_saturating_power_test.sv
`timescale 1ns / 1ps
module int64_alu_with_saturating_power_test;
    import i64alu_pkg::*;

    localparam logic [63:0] MAXPOS = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINNEG = 64'h8000_0000_0000_0000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 640;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    int64_alu_with_saturating_power dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out)
    );

    typedef struct {
        t_in  item;
        logic known;
        t_out res;
    } t_row;

    t_out expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    bit stall_enable = 1'b1;
    bit hold_off = 1'b0;
    bit sender_done = 1'b0;
    int pow_count = 0;
    int divmod_count = 0;
    int err_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] magnitude(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // returns 1 when a*b does not exceed the signed limit
    function automatic bit product_fits(logic [63:0] a, logic [63:0] b, bit neg,
                                        output logic [63:0] p);
        logic [63:0] lim;
        lim = neg ? MINNEG : MAXPOS;
        p = a * b;
        if (a != 0 && b > lim / a) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [63:0] saturating_power(logic [63:0] base, logic [63:0] expo);
        logic [31:0] e;
        logic [63:0] rmag, cmag, p;
        bit rneg, cneg, n;
        e = expo[31:0];
        rmag = 1;
        rneg = 0;
        if (expo[63]) return 0;
        if (e == 0) return 1;
        cmag = magnitude(base);
        cneg = base[63];
        if (cmag == 0) return 0;
        while (e != 0) begin
            if (e[0]) begin
                n = rneg ^ cneg;
                if (!product_fits(rmag, cmag, n, p)) return MAXPOS;
                rmag = p;
                rneg = n;
            end
            e = e >> 1;
            if (e != 0) begin
                if (!product_fits(cmag, cmag, 1'b0, p)) return MAXPOS;
                cmag = p;
                cneg = 0;
            end
        end
        return rneg ? -rmag : rmag;
    endfunction

    function automatic t_out alu_result(t_in it);
        logic [63:0] a, b, r, ma, mb;
        logic [1:0] err;
        a = it.lhs;
        b = it.rhs;
        r = 0;
        err = ERR_NONE;
        case (it.func)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_POW: r = saturating_power(a, b);
            OP_DIV, OP_MOD: begin
                if (b == 0) err = ERR_DIV0;
                else begin
                    ma = magnitude(a);
                    mb = magnitude(b);
                    if (it.func == OP_DIV) r = (a[63] != b[63]) ? -(ma / mb) : ma / mb;
                    else r = a[63] ? -(ma % mb) : ma % mb;
                end
            end
            OP_LT: r = $signed(a) < $signed(b);
            OP_LE: r = $signed(a) <= $signed(b);
            OP_GT: r = $signed(a) > $signed(b);
            OP_GE: r = $signed(a) >= $signed(b);
            OP_EQ: r = a == b;
            OP_NE: r = a != b;
            OP_OR: r = a | b;
            OP_AND: r = a & b;
            OP_LOR: r = (a != 0) || (b != 0);
            OP_LAND: r = (a != 0) && (b != 0);
            OP_SHL, OP_SHR: begin
                if (b[63] || b >= 64) err = ERR_SHIFT;
                else if (it.func == OP_SHL) r = a << b[5:0];
                else r = $signed(a) >>> b[5:0];
            end
            OP_PLUS: r = a;
            OP_NEG: r = -a;
            OP_LNOT: r = a == 0;
            OP_BNOT: r = ~a;
            default: r = 0;
        endcase
        return '{result: r, error_code: err};
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = 64'($urandom_range(0, 20));
            1: v = -64'($urandom_range(1, 20));
            2: v = v >> $urandom_range(0, 63);
            3: v = $signed(v) >>> $urandom_range(0, 63);
            4: v = MAXPOS - 64'($urandom_range(0, 3));
            5: v = MINNEG + 64'($urandom_range(0, 3));
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_in random_item();
        t_in it;
        it.func = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 9) < 8) it.func = 5'($urandom_range(0, 21));
        it.lhs = rand64();
        it.rhs = rand64();
        if (it.func == OP_POW && $urandom_range(0, 3) != 0) begin
            it.lhs = 64'($signed($urandom_range(0, 40)) - 20);
            it.rhs = 64'($urandom_range(0, 70));
        end
        if ((it.func == OP_SHL || it.func == OP_SHR) && $urandom_range(0, 3) != 0)
            it.rhs = 64'($urandom_range(0, 63));
        return it;
    endfunction

    task automatic send_item(t_in it, logic known, t_out res);
        t_out exp_res;
        logic stalled;
        exp_res = known ? res : alu_result(it);
        if (t_func'(it.func) == OP_POW) pow_count++;
        if (it.func == OP_DIV || it.func == OP_MOD) divmod_count++;
        if (exp_res.error_code != ERR_NONE) err_count++;
        i_in_valid <= 1'b1;
        i_in <= it;
        // stall is sampled between edges, where it holds its value for the next edge
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        expected_results.push_back(exp_res);
        items_sent++;
        if (stall_enable && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    t_row directed [25] = '{
        '{'{OP_ADD, MAXPOS, 64'd1}, 1'b1, '{MINNEG, ERR_NONE}},
        '{'{OP_SUB, MINNEG, 64'd1}, 1'b1, '{MAXPOS, ERR_NONE}},
        '{'{OP_MUL, MAXPOS, MAXPOS}, 1'b0, '{'0, ERR_NONE}},
        '{'{OP_POW, 64'd0, 64'd0}, 1'b1, '{64'd1, ERR_NONE}},
        '{'{OP_POW, 64'd5, 64'h1_0000_0000}, 1'b1, '{64'd1, ERR_NONE}},
        '{'{OP_POW, 64'd2, -64'sd1}, 1'b1, '{64'd0, ERR_NONE}},
        '{'{OP_POW, 64'd2, 64'd63}, 1'b1, '{MAXPOS, ERR_NONE}},
        '{'{OP_POW, -64'sd2, 64'd63}, 1'b1, '{MINNEG, ERR_NONE}},
        '{'{OP_POW, 64'd2, 64'd62}, 1'b0, '{'0, ERR_NONE}},
        '{'{OP_POW, 64'h1_0000_0000, 64'd2}, 1'b1, '{MAXPOS, ERR_NONE}},
        '{'{OP_DIV, MINNEG, -64'sd1}, 1'b1, '{MINNEG, ERR_NONE}},
        '{'{OP_MOD, MINNEG, -64'sd1}, 1'b1, '{64'd0, ERR_NONE}},
        '{'{OP_DIV, 64'd7, 64'd0}, 1'b1, '{64'd0, ERR_DIV0}},
        '{'{OP_MOD, -64'sd7, 64'd0}, 1'b1, '{64'd0, ERR_DIV0}},
        '{'{OP_MOD, -64'sd7, 64'd2}, 1'b1, '{-64'sd1, ERR_NONE}},
        '{'{OP_LT, MINNEG, MAXPOS}, 1'b1, '{64'd1, ERR_NONE}},
        '{'{OP_GE, MINNEG, MAXPOS}, 1'b1, '{64'd0, ERR_NONE}},
        '{'{OP_SHL, -64'sd1, 64'd63}, 1'b1, '{MINNEG, ERR_NONE}},
        '{'{OP_SHR, MINNEG, 64'd63}, 1'b1, '{-64'sd1, ERR_NONE}},
        '{'{OP_SHL, 64'd1, 64'd64}, 1'b1, '{64'd0, ERR_SHIFT}},
        '{'{OP_SHR, 64'd1, -64'sd1}, 1'b1, '{64'd0, ERR_SHIFT}},
        '{'{OP_NEG, MINNEG, 64'd0}, 1'b1, '{MINNEG, ERR_NONE}},
        '{'{OP_LNOT, 64'd0, 64'd0}, 1'b1, '{64'd1, ERR_NONE}},
        '{'{OP_BNOT, 64'd0, MAXPOS}, 1'b1, '{-64'sd1, ERR_NONE}},
        '{'{5'd31, -64'sd1, -64'sd1}, 1'b1, '{64'd0, ERR_NONE}}
    };

    // receiver side
    initial begin
        i_out_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) i_out_stall <= 1'b1;
            else if (stall_enable && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else i_out_stall <= 1'b0;
        end
    end

    // checker and watchdog, looking at the values the next rising edge takes
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h err %0d", $time, o_out.result,
                             o_out.error_code);
                    errors++;
                end else begin
                    t_out e;
                    e = expected_results.pop_front();
                    if (o_out.result !== e.result) begin
                        $display("%0t: result expected %h actual %h", $time, e.result,
                                 o_out.result);
                        errors++;
                    end
                    if (o_out.error_code !== e.error_code) begin
                        $display("%0t: error code expected %0d actual %0d", $time,
                                 e.error_code, o_out.error_code);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress, %0d results outstanding", $time,
                         expected_results.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_item(directed[k].item, directed[k].known, directed[k].res);
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 150) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (k == 300) begin
                i_in_valid <= 1'b0;
                wait (expected_results.size() == 0);
                @(posedge i_clk);
            end
            if (k == N_RANDOM - 80) stall_enable = 1'b0;
            send_item(random_item(), 1'b0, '{'0, ERR_NONE});
        end
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("sent %0d items, %0d results: %0d power, %0d div/mod, %0d error codes",
                 items_sent, results_seen, pow_count, divmod_count, err_count);
        if (errors == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/i64alu_pkg.sv
rtl/core/i64alu_ctrl.sv
rtl/core/i64alu_dp.sv
rtl/core/int64_alu_with_saturating_power.sv
bench/int64_alu_with_saturating_power_test.sv
